// File: src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define UDPB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// Condition must never be seen outside reset.
`define UDPB_NEVER(lbl, clk, rst_n, cond) \
  `UDPB_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// File: src/udpb_pkg.sv
// Types and constants of the UDP port demux table.
package udpb_pkg;

  // Table geometry; the item fields below are sized for these
  localparam int SOCKET_SLOTS = 16;
  localparam int QUEUE_DEPTH  = 32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] addr;
    logic [15:0] port;
    logic [3:0]  iface;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  sel_slot;
    logic [15:0] bound_port_out;
    logic        evicted;
    logic [5:0]  queued;
  } out_item_t;

  // Result of comparing one slot entry against a lookup key
  typedef struct packed {
    logic taken;
    logic dlv;
    logic exact;
    logic wild;
  } match_t;

  localparam logic [2:0] K_OPEN  = 3'd0;
  localparam logic [2:0] K_CLOSE = 3'd1;
  localparam logic [2:0] K_BIND  = 3'd2;
  localparam logic [2:0] K_IFACE = 3'd3;
  localparam logic [2:0] K_DLV   = 3'd4;
  localparam logic [2:0] K_RECV  = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_IN_USE    = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  localparam int          CFG_IDX_W   = 2;
  localparam logic [1:0]  CFG_EPH_MIN = 2'd0;
  localparam logic [1:0]  CFG_EPH_MAX = 2'd1;
  localparam logic [15:0] EPH_MIN_RST = 16'd49152;
  localparam logic [15:0] EPH_MAX_RST = 16'd65535;

endpackage

// File: src/udpb_slot_tbl.sv
// Socket slot table: flop storage, one read port, one write port.
module udpb_slot_tbl #(
  parameter int SLOTS = 16,
  parameter int IFB   = 4,
  parameter int CW    = 6,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [SW-1:0]  rd_idx,
  output logic           rd_used,
  output logic [31:0]    rd_addr,
  output logic [15:0]    rd_port,
  output logic [IFB-1:0] rd_pin,
  output logic [CW-1:0]  rd_cnt,
  input  logic           wr_en,
  input  logic [SW-1:0]  wr_idx,
  input  logic           wr_used,
  input  logic [31:0]    wr_addr,
  input  logic [15:0]    wr_port,
  input  logic [IFB-1:0] wr_pin,
  input  logic [CW-1:0]  wr_cnt
);

  logic           used_r [SLOTS];
  logic [31:0]    addr_r [SLOTS];
  logic [15:0]    port_r [SLOTS];
  logic [IFB-1:0] pin_r  [SLOTS];
  logic [CW-1:0]  cnt_r  [SLOTS];

  // Read the addressed entry
  assign rd_used = used_r[rd_idx];
  assign rd_addr = addr_r[rd_idx];
  assign rd_port = port_r[rd_idx];
  assign rd_pin  = pin_r[rd_idx];
  assign rd_cnt  = cnt_r[rd_idx];

  // Write one whole entry; reset clears the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        used_r[i] <= 1'b0;
        addr_r[i] <= '0;
        port_r[i] <= '0;
        pin_r[i]  <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (wr_en) begin
      used_r[wr_idx] <= wr_used;
      addr_r[wr_idx] <= wr_addr;
      port_r[wr_idx] <= wr_port;
      pin_r[wr_idx]  <= wr_pin;
      cnt_r[wr_idx]  <= wr_cnt;
    end
  end

endmodule

// File: src/udpb_match.sv
// Shared compare unit: one slot entry against the lookup key.
module udpb_match #(
  parameter int IFB = 4
) (
  input  logic             ent_used,
  input  logic [31:0]      ent_addr,
  input  logic [15:0]      ent_port,
  input  logic [IFB-1:0]   ent_pin,
  input  logic [31:0]      key_addr,
  input  logic [15:0]      key_port,
  input  logic [IFB-1:0]   key_pin,
  output udpb_pkg::match_t m
);
  import udpb_pkg::*;

  logic port_hit;
  logic pin_off_take;
  logic pin_off_dlv;

  assign port_hit     = ent_used && (ent_port == key_port);
  // A zero key pin ignores pinning in the conflict check
  assign pin_off_take = (key_pin != '0) && (ent_pin != '0) && (ent_pin != key_pin);
  // A pinned socket only takes datagrams from its own interface
  assign pin_off_dlv  = (ent_pin != '0) && (ent_pin != key_pin);

  assign m.taken = port_hit && !pin_off_take &&
                   ((key_addr == '0) || (ent_addr == '0) || (ent_addr == key_addr));
  assign m.dlv   = port_hit && (ent_port != '0) && !pin_off_dlv;
  assign m.exact = (ent_addr == key_addr);
  assign m.wild  = (ent_addr == '0);

endmodule

// File: src/udp_port_bind_demux_table_core.sv
// Top level of the UDP port demux table: sequencer around one compare unit.
//
//  channel | direction | handshake      | payload
//  in      | input     | in_valid/stall | udpb_pkg::in_item_t
//  out     | output    | out_valid/stall| udpb_pkg::out_item_t
//  cfg     | input     | cfg_valid/ready| cfg_index, cfg_data
//
// Open, deliver and port checks walk the slots one per cycle through the
// shared compare unit; close, set interface and receive read only the
// addressed slot. An ephemeral bind scans the slots once per candidate
// port, trying up to every port of the ephemeral range.
// Reset is synchronous and clears the table; in_stall stays high from
// accept until the result is loaded into the output register.
module udp_port_bind_demux_table_core #(
  parameter int IFACE_BITS   = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  udpb_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output udpb_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [udpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data
);
  import udpb_pkg::*;

  localparam int SW = $clog2(SOCKET_SLOTS);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SLOT  = 4'd1;
  localparam logic [3:0] S_OPEN  = 4'd2;
  localparam logic [3:0] S_DLV   = 4'd3;
  localparam logic [3:0] S_DQ    = 4'd4;
  localparam logic [3:0] S_TAKEN = 4'd5;
  localparam logic [3:0] S_EPH   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]      state_r, state_nxt;
  in_item_t        item_r, item_nxt;
  logic [SW-1:0]   idx_r, idx_nxt;
  logic [SW-1:0]   tgt_r, tgt_nxt;
  logic            slot_ok_r, slot_ok_nxt;
  logic [SW-1:0]   any_r, any_nxt;
  logic            any_v_r, any_v_nxt;
  logic [15:0]     cand_r, cand_nxt;
  logic [IFACE_BITS-1:0] ent_pin_r, ent_pin_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [16:0]     rem_r, rem_nxt;
  logic [15:0]     next_eph_r, next_eph_nxt;
  logic [15:0]     eph_min_r, eph_max_r;
  out_item_t       res_r, res_nxt;
  logic            out_valid_r;
  out_item_t       out_item_r;

  logic [SW-1:0]   rd_idx;
  logic            rd_used;
  logic [31:0]     rd_addr;
  logic [15:0]     rd_port;
  logic [IFACE_BITS-1:0] rd_pin;
  logic [CW-1:0]   rd_cnt;
  logic            wr_en;
  logic [SW-1:0]   wr_idx;
  logic            wr_used;
  logic [31:0]     wr_addr;
  logic [15:0]     wr_port;
  logic [IFACE_BITS-1:0] wr_pin;
  logic [CW-1:0]   wr_cnt;

  logic [15:0]     key_port;
  logic [IFACE_BITS-1:0] key_pin;
  logic [IFACE_BITS-1:0] ifc;
  match_t          m;
  logic            scan;
  logic            last;
  logic            out_free;

  assign ifc      = IFACE_BITS'(item_r.iface);
  assign scan     = (state_r == S_OPEN) || (state_r == S_DLV) || (state_r == S_TAKEN);
  assign rd_idx   = scan ? idx_r : tgt_r;
  assign last     = (idx_r == SW'(SOCKET_SLOTS - 1));
  assign out_free = !out_valid_r || !out_stall;

  // Key for the compare unit: deliver uses the datagram, bind the candidate
  assign key_port = (state_r == S_DLV) ? item_r.port : cand_r;
  assign key_pin  = (state_r == S_DLV) ? ifc :
                    ((item_r.port != '0) ? ent_pin_r : '0);

  udpb_slot_tbl #(
    .SLOTS (SOCKET_SLOTS),
    .IFB   (IFACE_BITS),
    .CW    (CW)
  ) u_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rd_idx),
    .rd_used (rd_used),
    .rd_addr (rd_addr),
    .rd_port (rd_port),
    .rd_pin  (rd_pin),
    .rd_cnt  (rd_cnt),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_used (wr_used),
    .wr_addr (wr_addr),
    .wr_port (wr_port),
    .wr_pin  (wr_pin),
    .wr_cnt  (wr_cnt)
  );

  udpb_match #(
    .IFB (IFACE_BITS)
  ) u_match (
    .ent_used (rd_used),
    .ent_addr (rd_addr),
    .ent_port (rd_port),
    .ent_pin  (rd_pin),
    .key_addr (item_r.addr),
    .key_port (key_port),
    .key_pin  (key_pin),
    .m        (m)
  );

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    idx_nxt      = idx_r;
    tgt_nxt      = tgt_r;
    slot_ok_nxt  = slot_ok_r;
    any_nxt      = any_r;
    any_v_nxt    = any_v_r;
    cand_nxt     = cand_r;
    ent_pin_nxt  = ent_pin_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    next_eph_nxt = next_eph_r;
    res_nxt      = res_r;
    wr_en        = 1'b0;
    wr_idx       = rd_idx;
    wr_used      = rd_used;
    wr_addr      = rd_addr;
    wr_port      = rd_port;
    wr_pin       = rd_pin;
    wr_cnt       = rd_cnt;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt    = in_item;
          tgt_nxt     = SW'(in_item.slot);
          slot_ok_nxt = (int'(in_item.slot) < SOCKET_SLOTS);
          idx_nxt     = '0;
          any_v_nxt   = 1'b0;
          case (in_item.kind)
            K_OPEN:  state_nxt = S_OPEN;
            K_DLV:   state_nxt = S_DLV;
            K_CLOSE, K_BIND, K_IFACE, K_RECV: state_nxt = S_SLOT;
            default: begin
              res_nxt   = '{ST_INVALID, 4'd0, 16'd0, 1'b0, 6'd0};
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      // Operate on the addressed slot
      S_SLOT: begin
        res_nxt   = '{ST_OK, item_r.slot, 16'd0, 1'b0, 6'(rd_cnt)};
        state_nxt = S_OUT;
        if (!(slot_ok_r && rd_used)) begin
          res_nxt.status = ST_INVALID;
          res_nxt.queued = '0;
        end else begin
          case (item_r.kind)
            K_CLOSE: begin
              wr_en   = 1'b1;
              wr_used = 1'b0;
              wr_addr = '0;
              wr_port = '0;
              wr_pin  = '0;
              wr_cnt  = '0;
              res_nxt.queued = '0;
            end
            K_IFACE: begin
              wr_en  = 1'b1;
              wr_pin = ifc;
            end
            K_RECV: begin
              if (rd_cnt == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                wr_en  = 1'b1;
                wr_cnt = rd_cnt - CW'(1);
                res_nxt.queued = 6'(rd_cnt - CW'(1));
              end
            end
            K_BIND: begin
              ent_pin_nxt = rd_pin;
              cnt_nxt     = rd_cnt;
              idx_nxt     = '0;
              if (rd_port != '0) begin
                res_nxt.status = ST_INVALID;
              end else if (item_r.port != '0) begin
                cand_nxt  = item_r.port;
                state_nxt = S_TAKEN;
              end else if (eph_min_r > eph_max_r) begin
                res_nxt.status = ST_FULL;
              end else begin
                if ((next_eph_r < eph_min_r) || (next_eph_r > eph_max_r)) begin
                  next_eph_nxt = eph_min_r;
                end
                rem_nxt   = 17'(eph_max_r) - 17'(eph_min_r) + 17'd1;
                state_nxt = S_EPH;
              end
            end
            default: res_nxt.status = ST_INVALID;
          endcase
        end
      end

      // Take the next ephemeral candidate; advance the pointer
      S_EPH: begin
        next_eph_nxt = (next_eph_r == eph_max_r) ? eph_min_r : next_eph_r + 16'd1;
        rem_nxt      = rem_r - 17'd1;
        idx_nxt      = '0;
        if (next_eph_r != '0) begin
          cand_nxt  = next_eph_r;
          state_nxt = S_TAKEN;
        end else if (rem_r == 17'd1) begin
          res_nxt   = '{ST_FULL, item_r.slot, 16'd0, 1'b0, 6'(cnt_r)};
          state_nxt = S_OUT;
        end
      end

      // Conflict scan for the candidate port
      S_TAKEN: begin
        if (m.taken) begin
          idx_nxt = '0;
          if (item_r.port != '0) begin
            res_nxt   = '{ST_IN_USE, item_r.slot, 16'd0, 1'b0, 6'(cnt_r)};
            state_nxt = S_OUT;
          end else if (rem_r == '0) begin
            res_nxt   = '{ST_FULL, item_r.slot, 16'd0, 1'b0, 6'(cnt_r)};
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_EPH;
          end
        end else if (last) begin
          wr_en     = 1'b1;
          wr_idx    = tgt_r;
          wr_used   = 1'b1;
          wr_addr   = item_r.addr;
          wr_port   = cand_r;
          wr_pin    = ent_pin_r;
          wr_cnt    = cnt_r;
          res_nxt   = '{ST_OK, item_r.slot, cand_r, 1'b0, 6'(cnt_r)};
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end

      // Find the first free slot
      S_OPEN: begin
        if (!rd_used) begin
          wr_en     = 1'b1;
          wr_used   = 1'b1;
          wr_addr   = '0;
          wr_port   = '0;
          wr_pin    = '0;
          wr_cnt    = '0;
          res_nxt   = '{ST_OK, 4'(idx_r), 16'd0, 1'b0, 6'd0};
          state_nxt = S_OUT;
        end else if (last) begin
          res_nxt   = '{ST_FULL, 4'd0, 16'd0, 1'b0, 6'd0};
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end

      // First exact match wins, else the last wildcard match
      S_DLV: begin
        if (m.dlv && m.exact) begin
          tgt_nxt   = idx_r;
          state_nxt = S_DQ;
        end else begin
          if (m.dlv && m.wild) begin
            any_nxt   = idx_r;
            any_v_nxt = 1'b1;
          end
          if (last) begin
            if (m.dlv && m.wild) begin
              tgt_nxt   = idx_r;
              state_nxt = S_DQ;
            end else if (any_v_r) begin
              tgt_nxt   = any_r;
              state_nxt = S_DQ;
            end else begin
              res_nxt   = '{ST_NOT_FOUND, 4'd0, 16'd0, 1'b0, 6'd0};
              state_nxt = S_OUT;
            end
          end else begin
            idx_nxt = idx_r + SW'(1);
          end
        end
      end

      // Enqueue, drop the oldest when full
      S_DQ: begin
        res_nxt   = '{ST_OK, 4'(tgt_r), 16'd0, 1'b0, 6'(rd_cnt)};
        state_nxt = S_OUT;
        if (rd_cnt >= CW'(QUEUE_DEPTH)) begin
          res_nxt.evicted = 1'b1;
        end else begin
          wr_en  = 1'b1;
          wr_cnt = rd_cnt + CW'(1);
          res_nxt.queued = 6'(rd_cnt + CW'(1));
        end
      end

      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_eph_r  <= EPH_MIN_RST;
      eph_min_r   <= EPH_MIN_RST;
      eph_max_r   <= EPH_MAX_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      next_eph_r <= next_eph_nxt;
      if (cfg_valid) begin
        if (cfg_index == CFG_EPH_MIN) begin
          eph_min_r <= cfg_data;
        end else if (cfg_index == CFG_EPH_MAX) begin
          eph_max_r <= cfg_data;
        end
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    idx_r     <= idx_nxt;
    tgt_r     <= tgt_nxt;
    slot_ok_r <= slot_ok_nxt;
    any_r     <= any_nxt;
    any_v_r   <= any_v_nxt;
    cand_r    <= cand_nxt;
    ent_pin_r <= ent_pin_nxt;
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    res_r     <= res_nxt;
    if ((state_r == S_OUT) && out_free) begin
      out_item_r <= res_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

endmodule

// File: src/udpb_chk.sv
// Port-level checker for the UDP port demux table, bound to the top level.
`include "assert_macros.svh"

module udpb_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input udpb_pkg::out_item_t            out_item
);
  import udpb_pkg::*;

  // Held result stays
  `UDPB_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
  `UDPB_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_item))
  // One item at a time: busy right after an accept
  `UDPB_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)
  // An eviction only comes with a successful deliver
  `UDPB_NEVER(a_evict_ok, clk, rst_n, out_valid && out_item.evicted && out_item.status != ST_OK)

endmodule

bind udp_port_bind_demux_table_core udpb_chk u_udpb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// File: sim/udpb_table_checker.sv
// Checker for the UDP port demux table: predicts each result and compares it.
module udpb_table_checker
  import udpb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_item_t               in_item,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_item_t              out_item,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]            cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam int SLOTS = 16;
  localparam int QDEPTH = 32;

  // Shadow of the socket table and the ephemeral range
  logic        sk_used [SLOTS];
  logic [31:0] sk_addr [SLOTS];
  logic [15:0] sk_port [SLOTS];
  logic [3:0]  sk_pin  [SLOTS];
  int          sk_qcnt [SLOTS];
  logic [15:0] eph_lo, eph_hi, eph_next;

  out_item_t awaited_results[$];

  assign pending = awaited_results.size();

  // Any live socket on this port whose address overlaps (pin 0 ignores pinning)
  function automatic bit port_busy(logic [3:0] pin, logic [31:0] a, logic [15:0] p);
    for (int i = 0; i < SLOTS; i++) begin
      if (!sk_used[i] || sk_port[i] != p) continue;
      if (pin != 0 && sk_pin[i] != 0 && sk_pin[i] != pin) continue;
      if (a == 0 || sk_addr[i] == 0 || sk_addr[i] == a) return 1;
    end
    return 0;
  endfunction

  // One round-robin lap over the ephemeral range; 0 when nothing is free
  function automatic logic [15:0] pick_ephemeral(logic [31:0] a);
    int span;
    logic [15:0] cand;
    if (eph_lo > eph_hi) return 16'd0;
    if (eph_next < eph_lo || eph_next > eph_hi) eph_next = eph_lo;
    span = int'(eph_hi) - int'(eph_lo) + 1;
    for (int t = 0; t < span; t++) begin
      cand = eph_next;
      eph_next = (cand == eph_hi) ? eph_lo : cand + 16'd1;
      if (cand != 0 && !port_busy(4'd0, a, cand)) return cand;
    end
    return 16'd0;
  endfunction

  // Apply one operation to the shadow table and return its result
  function automatic out_item_t apply_op(in_item_t it);
    out_item_t r;
    int hit, wild;
    logic [15:0] p;
    int s;
    r = '0;
    r.status = ST_INVALID;
    s = int'(it.slot);
    if (it.kind == K_OPEN) begin
      r.status = ST_FULL;
      for (int i = 0; i < SLOTS; i++) begin
        if (!sk_used[i]) begin
          sk_used[i] = 1'b1; sk_addr[i] = '0; sk_port[i] = '0; sk_pin[i] = '0;
          sk_qcnt[i] = 0;
          r.status = ST_OK;
          r.sel_slot = 4'(i);
          break;
        end
      end
    end else if (it.kind == K_DLV) begin
      hit = -1;
      wild = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!sk_used[i] || sk_port[i] == 0 || sk_port[i] != it.port) continue;
        if (sk_pin[i] != 0 && sk_pin[i] != it.iface) continue;
        if (sk_addr[i] == it.addr) begin
          hit = i;
          break;
        end
        if (sk_addr[i] == 0) wild = i;
      end
      if (hit < 0) hit = wild;
      if (hit < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        if (sk_qcnt[hit] >= QDEPTH) r.evicted = 1'b1;
        else sk_qcnt[hit]++;
        r.status = ST_OK;
        r.sel_slot = 4'(hit);
        r.queued = 6'(sk_qcnt[hit]);
      end
    end else if (it.kind <= K_RECV && sk_used[s]) begin
      r.sel_slot = it.slot;
      r.status = ST_OK;
      case (it.kind)
        K_CLOSE: begin
          sk_used[s] = 1'b0; sk_addr[s] = '0; sk_port[s] = '0; sk_pin[s] = '0;
          sk_qcnt[s] = 0;
        end
        K_BIND: begin
          if (sk_port[s] != 0) begin
            r.status = ST_INVALID;
          end else begin
            p = it.port;
            if (p == 0) begin
              p = pick_ephemeral(it.addr);
              if (p == 0) r.status = ST_FULL;
            end else if (port_busy(sk_pin[s], it.addr, p)) begin
              r.status = ST_IN_USE;
            end
            if (r.status == ST_OK) begin
              sk_addr[s] = it.addr;
              sk_port[s] = p;
              r.bound_port_out = p;
            end
          end
        end
        K_IFACE: sk_pin[s] = it.iface;
        K_RECV: begin
          if (sk_qcnt[s] == 0) r.status = ST_EMPTY;
          else sk_qcnt[s]--;
        end
        default: ;
      endcase
      r.queued = 6'(sk_qcnt[s]);
    end else if (it.kind <= K_RECV) begin
      r.sel_slot = it.slot;
    end
    return r;
  endfunction

  // Track config writes, predict accepted items, check delivered results
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        sk_used[i] = 1'b0; sk_addr[i] = '0; sk_port[i] = '0; sk_pin[i] = '0;
        sk_qcnt[i] = 0;
      end
      eph_lo = EPH_MIN_RST;
      eph_hi = EPH_MAX_RST;
      eph_next = EPH_MIN_RST;
      awaited_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_EPH_MIN) eph_lo = cfg_data;
        else if (cfg_index == CFG_EPH_MAX) eph_hi = cfg_data;
      end
      if (in_valid && !in_stall) begin
        awaited_results.insert(awaited_results.size(), apply_op(in_item));
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected item %p", out_item);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (out_item.status !== want.status || out_item.sel_slot !== want.sel_slot ||
              out_item.bound_port_out !== want.bound_port_out ||
              out_item.evicted !== want.evicted || out_item.queued !== want.queued) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, out_item);
          end
        end
      end
    end
  end

endmodule

// File: sim/tb_udp_port_bind_demux_table_core.sv
// Testbench top for the UDP port demux table: stimulus, idling and verdict.
module tb_udp_port_bind_demux_table_core;
  import udpb_pkg::*;

  localparam logic [2:0] K_UNKNOWN_A = 3'd6;
  localparam logic [2:0] K_UNKNOWN_B = 3'd7;
  localparam logic [31:0] HOST_A = 32'h0A00_0001;
  localparam logic [31:0] HOST_B = 32'h0A00_0002;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_item;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int fail_count, pending;
  int cycles = 0;
  bit no_gaps = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_left = 0;

  udp_port_bind_demux_table_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  udpb_table_checker i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[udp_port_bind_demux_table_core] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1;
      hold_left <= 400;
      hold_done <= 1;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(99) < 13);
    end
  end

  function automatic in_item_t mk(logic [2:0] k, logic [3:0] s, logic [31:0] a,
                                   logic [15:0] p, logic [3:0] f);
    in_item_t it;
    it.kind = k; it.slot = s; it.addr = a; it.port = p; it.iface = f;
    return it;
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return HOST_A;
      2: return HOST_B;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] any_port();
    return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
  endfunction

  function automatic logic [3:0] any_iface();
    return ($urandom_range(5) == 0) ? 4'($urandom) : 4'($urandom_range(2));
  endfunction

  function automatic in_item_t rand_op();
    int r;
    logic [2:0] k;
    r = $urandom_range(99);
    if (r < 14) k = K_OPEN;
    else if (r < 22) k = K_CLOSE;
    else if (r < 42) k = K_BIND;
    else if (r < 50) k = K_IFACE;
    else if (r < 80) k = K_DLV;
    else if (r < 95) k = K_RECV;
    else k = r[0] ? K_UNKNOWN_A : K_UNKNOWN_B;
    return mk(k, 4'($urandom_range(15)), pick_addr(), any_port(), any_iface());
  endfunction

  // Offer one item, at times after a random gap, and wait until it is taken
  task automatic push_op(in_item_t it);
    if (!no_gaps && $urandom_range(99) < 13) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write one register while the table is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // Random traffic, with bursts of deliveries to one endpoint to fill queues
  task automatic random_phase(int n, int phase);
    int sent;
    logic [31:0] a;
    logic [15:0] p;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(29) == 0) begin
        a = ($urandom_range(1) == 0) ? HOST_A : 32'd0;
        p = 16'($urandom_range(1, 6));
        repeat (36) push_op(mk(K_DLV, 4'($urandom_range(15)), a, p, 4'($urandom_range(2))));
        sent += 36;
      end else begin
        push_op(rand_op());
        sent++;
      end
      if (phase == 2 && sent > 100 && !hold_req) hold_req = 1;
    end
  endtask

  initial begin
    logic [15:0] lo_set [6];
    logic [15:0] hi_set [6];
    lo_set = '{16'd1, 16'd5, 16'd10, 16'd65535, 16'd2, 16'd49152};
    hi_set = '{16'd65535, 16'd5, 16'd3, 16'd65535, 16'd6, 16'd65535};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: every operation, conflicts, pinning, empty queue, bad kinds
    push_op(mk(K_OPEN, 4'd0, 32'd0, 16'd0, 4'd0));
    push_op(mk(K_OPEN, 4'd0, 32'd0, 16'd0, 4'd0));
    push_op(mk(K_OPEN, 4'd0, 32'd0, 16'd0, 4'd0));
    push_op(mk(K_BIND, 4'd0, 32'd0, 16'd7, 4'd0));
    push_op(mk(K_BIND, 4'd1, HOST_A, 16'd7, 4'd0));
    push_op(mk(K_BIND, 4'd1, HOST_A, 16'd0, 4'd0));
    push_op(mk(K_BIND, 4'd0, HOST_A, 16'd9, 4'd0));
    push_op(mk(K_IFACE, 4'd0, 32'd0, 16'd0, 4'd15));
    push_op(mk(K_DLV, 4'd0, HOST_B, 16'd7, 4'd3));
    push_op(mk(K_DLV, 4'd0, HOST_B, 16'd7, 4'd15));
    push_op(mk(K_DLV, 4'd0, HOST_B, 16'd0, 4'd15));
    push_op(mk(K_DLV, 4'd0, HOST_A, 16'd49152, 4'd0));
    push_op(mk(K_RECV, 4'd0, 32'd0, 16'd0, 4'd0));
    push_op(mk(K_RECV, 4'd0, 32'd0, 16'd0, 4'd0));
    push_op(mk(K_RECV, 4'd9, 32'd0, 16'd0, 4'd0));
    push_op(mk(K_UNKNOWN_A, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 4'd15));
    push_op(mk(K_UNKNOWN_B, 4'd0, 32'd0, 16'd0, 4'd0));
    push_op(mk(K_BIND, 4'd2, 32'hFFFF_FFFF, 16'hFFFF, 4'd0));
    push_op(mk(K_DLV, 4'd0, 32'hFFFF_FFFF, 16'hFFFF, 4'd15));
    push_op(mk(K_CLOSE, 4'd2, 32'd0, 16'd0, 4'd0));
    push_op(mk(K_CLOSE, 4'd2, 32'd0, 16'd0, 4'd0));

    // Random phases under several ephemeral ranges, extremes and empty range included
    random_phase(200, 0);
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_EPH_MIN, lo_set[ph]);
      write_reg(CFG_EPH_MAX, hi_set[ph]);
      no_gaps = (ph == 3);
      random_phase(205, ph + 1);
    end
    no_gaps = 0;

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[udp_port_bind_demux_table_core] OK");
    else
      $display("[udp_port_bind_demux_table_core] ERROR");
    $finish;
  end

endmodule
